@@ src/assert_macros.svh @@
// Assertion shorthands, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition leads to another in the next cycle.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/gmps_pkg.sv @@
package gmps_pkg;

  // Fixed field widths on the ports and of the configuration registers.
  localparam int CELL_IN_W  = 16;
  localparam int PATH_OUT_W = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int COLS_REG_W = 11;
  localparam int ROWS_REG_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

  // Position flags of one cell.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic done;
  } pos_t;

endpackage

@@ src/grid_min_path_sum_stream.sv @@
// Streaming minimum path sum. Feed grid cells in row-major order, one item
// per cycle; each item returns one item holding the cheapest right/down path
// sum from the top-left cell, with tlast on the bottom-right cell, after
// which the position restarts for the next grid. Throughput is one item per
// clock while the output is not stalled, set by the row buffer: each cell's
// column entry is read when the item is taken and written back when the item
// leaves stage one (a back-to-back hit on the same entry, as with a
// one-column grid, is forwarded from the left-sum register). out_tvalid is
// registered: a result passes stage one and then the output register, and
// a stalled output holds stage one and then the input. Sums saturate at
// 2^SUM_WIDTH-1. Write grid_cols and grid_rows only while the block is idle;
// the buffer needs no clearing pass.
`include "assert_macros.svh"

module grid_min_path_sum_stream import gmps_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int SUM_WIDTH  = 32,
  parameter int CELL_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CELL_IN_W-1:0]  in_tdata,   // [15:0] cell_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PATH_OUT_W-1:0] out_tdata,  // [31:0] path_sum
  output logic                  out_tlast   // grid_done
);

  localparam int CIW = $clog2(MAX_COLS);
  localparam logic [CELL_IN_W-1:0] CELL_MASK = (CELL_WIDTH >= CELL_IN_W) ? '1 :
      CELL_IN_W'((64'd1 << CELL_WIDTH) - 64'd1);

  logic                  accept, s1_adv;
  logic [CIW-1:0]        col;
  pos_t                  pos;
  logic                  s1_v_r;
  pos_t                  s1_pos_r;
  logic [CIW-1:0]        s1_col_r;
  logic [CELL_IN_W-1:0]  s1_cell_r;
  logic                  fwd_r;
  logic [SUM_WIDTH-1:0]  ram_rdata, sum;
  logic                  out_v_r, out_last_r;
  logic [PATH_OUT_W-1:0] out_sum_r;

  // Stage one moves on when the output register is free or being drained;
  // a new item may enter in the same cycle.
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  gmps_pos #(.MAX_COLS(MAX_COLS)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .adv       (accept),
    .col       (col),
    .pos       (pos)
  );

  // Row buffer: read the entry above on accept, write the new sum back
  // when the item leaves stage one.
  gmps_ram #(.WIDTH(SUM_WIDTH), .DEPTH(MAX_COLS)) u_row_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (sum),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  gmps_sum #(.SUM_WIDTH(SUM_WIDTH)) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .pos      (s1_pos_r),
    .up_ram   (ram_rdata),
    .fwd      (fwd_r),
    .cell_val (s1_cell_r),
    .sum      (sum)
  );

  // Stage one: hold the taken item while its buffer read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        // Flag a read that races the write-back of the same entry.
        fwd_r  <= s1_adv && (s1_col_r == col);
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= pos;
      s1_col_r  <= col;
      s1_cell_r <= in_tdata & CELL_MASK;
    end
  end

  // Output register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum_r  <= PATH_OUT_W'(sum);
      out_last_r <= s1_pos_r.done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sum_r;
  assign out_tlast  = out_last_r;

  // A result only appears after stage one held an item.
  `ASSERT_CLK(a_out_from_s1, $rose(out_tvalid) |-> $past(s1_v_r))
  // A stalled output keeps stage one full: nothing is dropped.
  `ASSERT_NEXT(a_stall_holds, s1_v_r && out_v_r && !out_tready, s1_v_r && out_v_r)
  // The bottom-right cell carries its flag into stage one.
  `ASSERT_NEXT(a_done_tracked, accept && pos.done, s1_v_r && s1_pos_r.done)
  // Forwarding only ever applies to an item in stage one.
  `ASSERT_CLK(a_fwd_valid, fwd_r && !s1_v_r |-> !s1_adv)

endmodule

@@ src/gmps_ram.sv @@
module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/gmps_pos.sv @@
module gmps_pos import gmps_pkg::*; #(
  parameter int MAX_COLS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        adv,
  output logic [$clog2(MAX_COLS)-1:0] col,
  output pos_t                        pos
);

  localparam int CIW   = $clog2(MAX_COLS);
  localparam int CMP_W = CIW + COLS_REG_W + 1;

  logic [COLS_REG_W-1:0] grid_cols_r;
  logic [ROWS_REG_W-1:0] grid_rows_r;
  logic [CIW-1:0]        col_r, col_nxt;
  logic [ROWS_REG_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0]      cols_eff, col_p1;
  logic [ROWS_REG_W:0]   rows_eff, row_p1;
  logic                  last_col, last_row;

  always_comb begin
    // Clamp the column count into 1..MAX_COLS, the row count to at least 1.
    if (grid_cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(grid_cols_r) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(grid_cols_r);
    end
    rows_eff = (grid_rows_r == '0) ? (ROWS_REG_W+1)'(1) : {1'b0, grid_rows_r};
    col_p1   = CMP_W'(col_r) + CMP_W'(1);
    row_p1   = {1'b0, row_r} + (ROWS_REG_W+1)'(1);
    last_col = col_p1 >= cols_eff;
    last_row = row_p1 >= rows_eff;

    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_p1[ROWS_REG_W-1:0];
      end else begin
        col_nxt = col_p1[CIW-1:0];
      end
    end
  end

  assign col           = col_r;
  assign pos.first_row = (row_r == '0);
  assign pos.first_col = (col_r == '0);
  assign pos.done      = last_col && last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= COLS_REG_W'(1024);
      grid_rows_r <= ROWS_REG_W'(1);
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_GRID_COLS: grid_cols_r <= cfg_wdata[COLS_REG_W-1:0];
          CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[ROWS_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/gmps_sum.sv @@
module gmps_sum import gmps_pkg::*; #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  pos_t                 pos,
  input  logic [SUM_WIDTH-1:0] up_ram,
  input  logic                 fwd,
  input  logic [CELL_IN_W-1:0] cell_val,
  output logic [SUM_WIDTH-1:0] sum
);

  logic [SUM_WIDTH-1:0] left_sum_r;
  logic [SUM_WIDTH-1:0] up, base;
  logic [SUM_WIDTH:0]   raw;

  always_comb begin
    // Take the sum above from the write in flight when it hit the same entry.
    up = fwd ? left_sum_r : up_ram;
    if (pos.first_row && pos.first_col) begin
      base = '0;
    end else if (pos.first_row) begin
      base = left_sum_r;
    end else if (pos.first_col) begin
      base = up;
    end else begin
      base = (up < left_sum_r) ? up : left_sum_r;
    end
    raw = {1'b0, base} + (SUM_WIDTH+1)'(cell_val);
    sum = raw[SUM_WIDTH] ? '1 : raw[SUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r <= '0;
    end else if (adv) begin
      left_sum_r <= sum;
    end
  end

endmodule
